/* src/jddm_pkg.sv */
// shared types, constants and the drive select table for the joystick mixer
`timescale 1ns / 1ps
package jddm_pkg;

  localparam int unsigned AXIS_W = 12;
  localparam int unsigned DUTY_W = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SEL_IDX_W = 5;
  localparam int unsigned SEL_COUNT = 21;

  localparam logic [AXIS_W-1:0] FULL_SCALE = 12'd4095;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT = 2'd3;

  localparam logic [AXIS_W-1:0] DEADBAND_RST = 12'd400;
  localparam logic [AXIS_W-1:0] SNAP_RST = 12'd3900;
  localparam logic [AXIS_W-1:0] STILL_RST = 12'd20;
  localparam logic [AXIS_W-1:0] STRAIGHT_RST = 12'd10;

  // select table indexes; octants follow as (big, not big) pairs
  localparam logic [SEL_IDX_W-1:0] SEL_STILL = 5'd0;
  localparam logic [SEL_IDX_W-1:0] SEL_FWD = 5'd1;
  localparam logic [SEL_IDX_W-1:0] SEL_BACK = 5'd2;
  localparam logic [SEL_IDX_W-1:0] SEL_SPOT_L = 5'd3;
  localparam logic [SEL_IDX_W-1:0] SEL_SPOT_R = 5'd4;
  localparam logic [SEL_IDX_W-1:0] SEL_OCT_BASE = 5'd5;

  typedef struct packed {
    logic ld;
    logic rd;
    logic lf;
    logic lx;
    logic ly;
    logic rf;
    logic rx;
    logic ry;
  } drive_sel_t;

  // one mapped axis as sign flags and magnitude
  typedef struct packed {
    logic              neg;
    logic              pos;
    logic [AXIS_W-1:0] mag;
  } axis_t;

  typedef struct packed {
    logic              match;
    logic              left_dir;
    logic              right_dir;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
  } mix_res_t;

  localparam drive_sel_t SEL_TAB [SEL_COUNT] = '{
    8'b0000_0000, 8'b1100_1001, 8'b0000_1001,
    8'b0101_0010, 8'b1001_0010,
    8'b1001_0101, 8'b1010_1010,
    8'b1100_1110, 8'b1111_0001,
    8'b1111_0001, 8'b1100_1110,
    8'b0110_1010, 8'b0101_0101,
    8'b0101_0101, 8'b0110_1010,
    8'b0000_1110, 8'b0011_0001,
    8'b0011_0001, 8'b0000_1110,
    8'b1010_1010, 8'b1001_0101
  };

endpackage

/* src/jddm_axis.sv */
// maps one raw converter sample to a signed axis with deadband and snap
`timescale 1ns / 1ps
module jddm_axis (
  input  logic [jddm_pkg::AXIS_W-1:0] raw,
  input  logic [jddm_pkg::AXIS_W-1:0] deadband_limit,
  input  logic [jddm_pkg::AXIS_W-1:0] snap_limit,
  output jddm_pkg::axis_t             axis
);
  import jddm_pkg::*;

  logic [AXIS_W:0]   twice;
  logic              below_mid;
  logic [AXIS_W:0]   dev;
  logic [AXIS_W-1:0] mag_raw;
  logic              zeroed;

  always_comb begin
    twice = {raw, 1'b0};
    below_mid = ~raw[AXIS_W-1];
    // 2*raw - 4095 is always odd, so never zero before the deadband
    dev = below_mid ? ({1'b0, FULL_SCALE} - twice) : (twice - {1'b0, FULL_SCALE});
    mag_raw = dev[AXIS_W-1:0];
    zeroed = mag_raw < deadband_limit;
    axis.neg = below_mid & ~zeroed;
    axis.pos = ~below_mid & ~zeroed;
    if (zeroed) begin
      axis.mag = '0;
    end else if (mag_raw > snap_limit) begin
      axis.mag = FULL_SCALE;
    end else begin
      axis.mag = mag_raw;
    end
  end

endmodule

/* src/jddm_mix.sv */
// priority chain, select table lookup and duty arithmetic for both sides
`timescale 1ns / 1ps
module jddm_mix (
  input  jddm_pkg::axis_t             x,
  input  jddm_pkg::axis_t             y,
  input  logic [jddm_pkg::AXIS_W-1:0] still_limit,
  input  logic [jddm_pkg::AXIS_W-1:0] straight_limit,
  output jddm_pkg::mix_res_t          res
);
  import jddm_pkg::*;

  logic [AXIS_W:0]    mag_sum;
  logic               not_big;
  logic [2:0]         oct;
  logic               found;
  logic [SEL_IDX_W-1:0] idx;
  drive_sel_t         sel;

  function automatic logic [DUTY_W-1:0] duty_calc(
    input logic              f,
    input logic              sx,
    input logic              sy,
    input logic [AXIS_W-1:0] ax,
    input logic [AXIS_W-1:0] ay
  );
    logic signed [DUTY_W+1:0] d;
    logic signed [DUTY_W+1:0] a;
    d = $signed({3'b000, f ? FULL_SCALE : {AXIS_W{1'b0}}})
      - $signed({3'b000, sx ? ax : {AXIS_W{1'b0}}})
      - $signed({3'b000, sy ? ay : {AXIS_W{1'b0}}});
    a = d[DUTY_W+1] ? -d : d;
    return a[DUTY_W-1:0];
  endfunction

  always_comb begin
    mag_sum = {1'b0, x.mag} + {1'b0, y.mag};
    not_big = mag_sum <= {1'b0, FULL_SCALE};
    found = 1'b1;
    oct = 3'd0;
    if (x.pos && y.neg) begin
      oct = (x.mag >= y.mag) ? 3'd0 : 3'd1;
    end else if (x.neg && y.neg) begin
      oct = (y.mag > x.mag) ? 3'd2 : 3'd3;
    end else if (x.neg && y.pos) begin
      oct = (x.mag > y.mag) ? 3'd4 : 3'd5;
    end else if (x.pos && y.pos) begin
      oct = (y.mag >= x.mag) ? 3'd6 : 3'd7;
    end else begin
      found = 1'b0;
    end

    if (x.mag < still_limit && y.mag < still_limit) begin
      idx = SEL_STILL;
    end else if (x.mag < straight_limit && y.neg) begin
      idx = SEL_FWD;
    end else if (x.mag < straight_limit && y.pos) begin
      idx = SEL_BACK;
    end else if (x.neg && y.mag <= still_limit) begin
      idx = SEL_SPOT_L;
    end else if (x.pos && y.mag <= still_limit) begin
      idx = SEL_SPOT_R;
    end else begin
      idx = SEL_OCT_BASE + {1'b0, oct, not_big};
      res.match = found;
    end
    if (idx < SEL_OCT_BASE) begin
      res.match = 1'b1;
    end else begin
      res.match = found;
    end

    sel = SEL_TAB[idx];
    res.left_dir = sel.ld;
    res.right_dir = sel.rd;
    res.left_duty = duty_calc(sel.lf, sel.lx, sel.ly, x.mag, y.mag);
    res.right_duty = duty_calc(sel.rf, sel.rx, sel.ry, x.mag, y.mag);
  end

endmodule

/* src/joystick_differential_drive_mixer.sv */
// top level: input register, mixer logic and result register with hold state
//
// joystick differential-drive mixer
// input channel: in_raw_x, in_raw_y (12-bit converter samples) and
//   in_button_level, transferred when in_valid and in_ready are both high
// result channel: out_left_dir, out_right_dir, out_left_duty, out_right_duty
//   and out_hold_active, transferred when out_valid and out_ready are high
// config channel: cfg_index selects deadband, snap, still or straight limit,
//   cfg_data is written on a cfg_valid transfer; cfg_ready is always high
// path: an input passes the input register and then the result register
// throughput: one item per cycle while out_ready is high; the path from the
//   input register through axis mapping, the priority chain and the duty adders is combinational
// when out_ready is low the result stays put and one further item waits in
//   the input register; in_ready drops only when both are full
// reset clears hold mode, the button history, the held outputs and both
//   valid flags, and loads the default limits 400, 3900, 20 and 10
`timescale 1ns / 1ps
module joystick_differential_drive_mixer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [jddm_pkg::AXIS_W-1:0]    in_raw_x,
  input  logic [jddm_pkg::AXIS_W-1:0]    in_raw_y,
  input  logic                           in_button_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_left_dir,
  output logic                           out_right_dir,
  output logic [jddm_pkg::DUTY_W-1:0]    out_left_duty,
  output logic [jddm_pkg::DUTY_W-1:0]    out_right_duty,
  output logic                           out_hold_active,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jddm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jddm_pkg::AXIS_W-1:0]    cfg_data
);
  import jddm_pkg::*;

  logic [AXIS_W-1:0] deadband_r;
  logic [AXIS_W-1:0] snap_r;
  logic [AXIS_W-1:0] still_r;
  logic [AXIS_W-1:0] straight_r;

  logic              s1_valid_r;
  logic [AXIS_W-1:0] s1_raw_x_r;
  logic [AXIS_W-1:0] s1_raw_y_r;
  logic              s1_button_r;

  logic              out_valid_r;
  logic              left_dir_r;
  logic              right_dir_r;
  logic [DUTY_W-1:0] left_duty_r;
  logic [DUTY_W-1:0] right_duty_r;
  logic              hold_r;
  logic              last_button_r;

  logic              advance;
  logic              hold_nxt;
  axis_t             ax_x;
  axis_t             ax_y;
  mix_res_t          mix;

  jddm_axis u_axis_x (
    .raw            (s1_raw_x_r),
    .deadband_limit (deadband_r),
    .snap_limit     (snap_r),
    .axis           (ax_x)
  );

  jddm_axis u_axis_y (
    .raw            (s1_raw_y_r),
    .deadband_limit (deadband_r),
    .snap_limit     (snap_r),
    .axis           (ax_y)
  );

  jddm_mix u_mix (
    .x              (ax_x),
    .y              (ax_y),
    .still_limit    (still_r),
    .straight_limit (straight_r),
    .res            (mix)
  );

  assign advance = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | advance;
  assign cfg_ready = 1'b1;
  // rising button edge toggles hold before this sample is considered
  assign hold_nxt = hold_r ^ (s1_button_r & ~last_button_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RST;
      snap_r <= SNAP_RST;
      still_r <= STILL_RST;
      straight_r <= STRAIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEADBAND: deadband_r <= cfg_data;
        CFG_SNAP:     snap_r <= cfg_data;
        CFG_STILL:    still_r <= cfg_data;
        CFG_STRAIGHT: straight_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_raw_x_r <= in_raw_x;
      s1_raw_y_r <= in_raw_y;
      s1_button_r <= in_button_level;
    end
  end

  // the result register doubles as the held output state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_r <= 1'b0;
      last_button_r <= 1'b0;
      left_dir_r <= 1'b0;
      right_dir_r <= 1'b0;
      left_duty_r <= '0;
      right_duty_r <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        hold_r <= hold_nxt;
        last_button_r <= s1_button_r;
        if (!hold_nxt && mix.match) begin
          left_dir_r <= mix.left_dir;
          right_dir_r <= mix.right_dir;
          left_duty_r <= mix.left_duty;
          right_duty_r <= mix.right_duty;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_left_dir = left_dir_r;
  assign out_right_dir = right_dir_r;
  assign out_left_duty = left_duty_r;
  assign out_right_duty = right_duty_r;
  assign out_hold_active = hold_r;

endmodule
